### sv/pvt_sensor_code_conversion_assert.svh
// Assertion macros shared by the PVT code conversion RTL
`ifndef PVT_SENSOR_CODE_CONVERSION_ASSERT_SVH
`define PVT_SENSOR_CODE_CONVERSION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define PVTCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvtcc: implication check failed");

// implication with a fixed delay in cycles
`define PVTCC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("pvtcc: delayed check failed");

`else

`define PVTCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PVTCC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons)

`endif

`endif

### sv/pvtcc_pkg.sv
// Types and constants shared by the PVT code conversion pipeline
`default_nettype none

package pvtcc_pkg;

    // port field widths
    localparam int OP_W   = 2;
    localparam int CODE_W = 10;
    localparam int PHYS_W = 32;
    localparam int OUT_W  = 19;

    // datapath shape: four polynomial terms, up to four multiply/divide steps each
    localparam int NLANE  = 4;
    localparam int NSTEP  = 4;
    localparam int VAL_W  = 20;   // lane value, holds every coefficient and partial term
    localparam int OPND_W = 18;   // shared multiplier operand (code, clamped input, scale)
    localparam int MAG_W  = 31;   // magnitude of a lane product before division
    localparam int DIV_W  = 3;

    // accepting edge to the edge that takes the result
    localparam int RES_LAT = 10;

    typedef enum logic [OP_W-1:0] {
        OP_C2T = 2'd0,   // code to millidegrees
        OP_T2C = 2'd1,   // millidegrees to code
        OP_C2V = 2'd2,   // code to millivolts
        OP_V2C = 2'd3    // millivolts to code
    } t_op;

    // divisor applied by one step of one lane; none means the lane idles
    typedef enum logic [DIV_W-1:0] {
        DIV_NONE  = 3'd0,
        DIV_1000  = 3'd1,
        DIV_1E6   = 3'd2,
        DIV_1E5   = 3'd3,
        DIV_18658 = 3'd4,
        DIV_10000 = 3'd5
    } t_div;

    typedef logic signed [VAL_W-1:0]             t_val;
    typedef logic signed [OPND_W-1:0]            t_opnd;
    typedef logic [NLANE-1:0][DIV_W-1:0]         t_div_row;
    typedef logic [NSTEP-1:0][NLANE-1:0][DIV_W-1:0] t_sched;
    typedef logic [NLANE-1:0][VAL_W-1:0]         t_lanes;

    // one item in flight between steps; row 0 of sched is the next step's work
    typedef struct packed {
        t_op    op;
        t_opnd  opnd;
        t_sched sched;
        t_lanes val;
    } t_item;

endpackage

`default_nettype wire

### sv/pvtcc_prep.sv
// Input stage: clamps, picks the operand and loads lane coefficients and step schedule
`default_nettype none

module pvtcc_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [pvtcc_pkg::OP_W-1:0]          i_op,
    input  logic [pvtcc_pkg::CODE_W-1:0]        i_sensor_code,
    input  logic signed [pvtcc_pkg::PHYS_W-1:0] i_physical_value,
    output logic                                o_valid,
    output pvtcc_pkg::t_item                    o_item
);

    localparam int VAL_W  = pvtcc_pkg::VAL_W;
    localparam int OPND_W = pvtcc_pkg::OPND_W;

    // polynomial coefficients
    localparam int signed C_T4 = -16743;
    localparam int signed C_T3 = 81542;
    localparam int signed C_T2 = -182010;
    localparam int signed C_T1 = 310200;
    localparam int signed C_D3 = 2617;
    localparam int signed C_D2 = 8654;
    localparam int signed C_D1 = 3923;

    // linear scales
    localparam int signed MV_SCALE   = 10000;
    localparam int signed CODE_SLOPE = 18658;

    // input saturation limits
    localparam int signed T_MIN = -40000;
    localparam int signed T_MAX = 125000;
    localparam int signed V_MIN = 800;
    localparam int signed V_MAX = 1000;

    pvtcc_pkg::t_opnd temp_c;
    pvtcc_pkg::t_opnd volt_c;
    pvtcc_pkg::t_item n_item;
    pvtcc_pkg::t_item r_item;
    logic             r_valid;

    // saturate the physical input for both inverse conversions
    always_comb begin
        if (i_physical_value > T_MAX) begin
            temp_c = OPND_W'(T_MAX);
        end else if (i_physical_value < T_MIN) begin
            temp_c = OPND_W'(T_MIN);
        end else begin
            temp_c = OPND_W'(i_physical_value);
        end

        if (i_physical_value > V_MAX) begin
            volt_c = OPND_W'(V_MAX);
        end else if (i_physical_value < V_MIN) begin
            volt_c = OPND_W'(V_MIN);
        end else begin
            volt_c = OPND_W'(i_physical_value);
        end
    end

    // lane setup per conversion; unused lanes start at zero and never step
    always_comb begin
        n_item    = '0;
        n_item.op = pvtcc_pkg::t_op'(i_op);
        case (pvtcc_pkg::t_op'(i_op))
            pvtcc_pkg::OP_C2T: begin
                n_item.opnd   = OPND_W'(i_sensor_code);
                n_item.val[0] = VAL_W'(C_T4);
                n_item.val[1] = VAL_W'(C_T3);
                n_item.val[2] = VAL_W'(C_T2);
                n_item.val[3] = VAL_W'(C_T1);
                // fourth, third, second and first order terms
                n_item.sched[0][0] = pvtcc_pkg::DIV_1000;
                n_item.sched[1][0] = pvtcc_pkg::DIV_1000;
                n_item.sched[2][0] = pvtcc_pkg::DIV_1000;
                n_item.sched[3][0] = pvtcc_pkg::DIV_1000;
                n_item.sched[0][1] = pvtcc_pkg::DIV_1000;
                n_item.sched[1][1] = pvtcc_pkg::DIV_1000;
                n_item.sched[2][1] = pvtcc_pkg::DIV_1000;
                n_item.sched[0][2] = pvtcc_pkg::DIV_1000;
                n_item.sched[1][2] = pvtcc_pkg::DIV_1000;
                n_item.sched[0][3] = pvtcc_pkg::DIV_1000;
            end
            pvtcc_pkg::OP_T2C: begin
                n_item.opnd   = temp_c;
                n_item.val[0] = VAL_W'(C_D3);
                n_item.val[1] = VAL_W'(C_D2);
                n_item.val[2] = VAL_W'(C_D1);
                // cubic term ends with a divide by 1e5
                n_item.sched[0][0] = pvtcc_pkg::DIV_1E6;
                n_item.sched[1][0] = pvtcc_pkg::DIV_1E6;
                n_item.sched[2][0] = pvtcc_pkg::DIV_1E5;
                n_item.sched[0][1] = pvtcc_pkg::DIV_1E6;
                n_item.sched[1][1] = pvtcc_pkg::DIV_1E6;
                n_item.sched[0][2] = pvtcc_pkg::DIV_1E6;
            end
            pvtcc_pkg::OP_C2V: begin
                n_item.opnd        = OPND_W'(MV_SCALE);
                n_item.val[0]      = VAL_W'(i_sensor_code);
                n_item.sched[0][0] = pvtcc_pkg::DIV_18658;
            end
            pvtcc_pkg::OP_V2C: begin
                n_item.opnd        = OPND_W'(CODE_SLOPE);
                n_item.val[0]      = VAL_W'(volt_c);
                n_item.sched[0][0] = pvtcc_pkg::DIV_10000;
            end
            default: begin
                n_item.opnd = '0;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### sv/pvtcc_step.sv
// One multiply/divide step of every lane, two register stages
`default_nettype none
`include "pvt_sensor_code_conversion_assert.svh"

module pvtcc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pvtcc_pkg::t_item i_item,
    output logic             o_valid,
    output pvtcc_pkg::t_item o_item
);

    localparam int NLANE  = pvtcc_pkg::NLANE;
    localparam int VAL_W  = pvtcc_pkg::VAL_W;
    localparam int OPND_W = pvtcc_pkg::OPND_W;
    localparam int MAG_W  = pvtcc_pkg::MAG_W;
    localparam int DIV_W  = pvtcc_pkg::DIV_W;
    localparam int PROD_W = VAL_W + OPND_W;
    localparam int MG_W   = 32;
    localparam int WIDE_W = MAG_W + MG_W;
    localparam int ROW_W  = NLANE * DIV_W;

    // reciprocal constants: m = ceil(2^k / d), k = MAG_W + ceil(log2 d),
    // exact floor division for every numerator below 2^MAG_W
    localparam int SH_1000  = MAG_W + 10;
    localparam int SH_1E6   = MAG_W + 20;
    localparam int SH_1E5   = MAG_W + 17;
    localparam int SH_18658 = MAG_W + 15;
    localparam int SH_10000 = MAG_W + 14;
    localparam logic [MG_W-1:0] MG_1000  =
        MG_W'(((64'd1 << SH_1000) + 64'd999) / 64'd1000);
    localparam logic [MG_W-1:0] MG_1E6   =
        MG_W'(((64'd1 << SH_1E6) + 64'd999999) / 64'd1000000);
    localparam logic [MG_W-1:0] MG_1E5   =
        MG_W'(((64'd1 << SH_1E5) + 64'd99999) / 64'd100000);
    localparam logic [MG_W-1:0] MG_18658 =
        MG_W'(((64'd1 << SH_18658) + 64'd18657) / 64'd18658);
    localparam logic [MG_W-1:0] MG_10000 =
        MG_W'(((64'd1 << SH_10000) + 64'd9999) / 64'd10000);

    // item between the multiply and the divide register
    typedef struct packed {
        pvtcc_pkg::t_op               op;
        pvtcc_pkg::t_opnd             opnd;
        pvtcc_pkg::t_div_row          cur;
        pvtcc_pkg::t_sched            sched;
        logic [NLANE-1:0]             neg;
        logic [NLANE-1:0][MAG_W-1:0]  mag;
    } t_mid;

    function automatic logic [MG_W-1:0] div_magic(input logic [DIV_W-1:0] code);
        case (pvtcc_pkg::t_div'(code))
            pvtcc_pkg::DIV_1000:  div_magic = MG_1000;
            pvtcc_pkg::DIV_1E6:   div_magic = MG_1E6;
            pvtcc_pkg::DIV_1E5:   div_magic = MG_1E5;
            pvtcc_pkg::DIV_18658: div_magic = MG_18658;
            pvtcc_pkg::DIV_10000: div_magic = MG_10000;
            default:              div_magic = '0;
        endcase
    endfunction

    wire  [NLANE-1:0]            mul_neg;
    wire  [NLANE-1:0][MAG_W-1:0] mul_mag;
    wire  [NLANE-1:0][VAL_W-1:0] div_val;
    t_mid                        n_mid;
    t_mid                        r_mid;
    logic                        r_mid_valid;
    pvtcc_pkg::t_item            n_item;
    pvtcc_pkg::t_item            r_item;
    logic                        r_valid;

    // per lane datapath
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        logic signed [VAL_W-1:0]  v_in;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sel;
        logic        [PROD_W-1:0] absv;
        logic        [WIDE_W-1:0] wide;
        logic        [VAL_W-1:0]  q;

        // multiply by the shared operand, split into sign and magnitude
        assign v_in = i_item.val[l];
        assign prod = PROD_W'(v_in) * PROD_W'(i_item.opnd);
        assign sel  = (i_item.sched[0][l] == pvtcc_pkg::DIV_NONE) ? PROD_W'(v_in) : prod;
        assign absv = sel[PROD_W-1] ? PROD_W'(-sel) : PROD_W'(sel);
        assign mul_neg[l] = sel[PROD_W-1];
        assign mul_mag[l] = absv[MAG_W-1:0];

        // divide by reciprocal multiply, quotient truncates toward zero
        assign wide = WIDE_W'(r_mid.mag[l]) * WIDE_W'(div_magic(r_mid.cur[l]));

        always_comb begin
            case (pvtcc_pkg::t_div'(r_mid.cur[l]))
                pvtcc_pkg::DIV_1000:  q = VAL_W'(wide >> SH_1000);
                pvtcc_pkg::DIV_1E6:   q = VAL_W'(wide >> SH_1E6);
                pvtcc_pkg::DIV_1E5:   q = VAL_W'(wide >> SH_1E5);
                pvtcc_pkg::DIV_18658: q = VAL_W'(wide >> SH_18658);
                pvtcc_pkg::DIV_10000: q = VAL_W'(wide >> SH_10000);
                default:              q = VAL_W'(r_mid.mag[l]);
            endcase
        end

        assign div_val[l] = r_mid.neg[l] ? VAL_W'(-q) : q;
    end

    // multiply stage: take this step's row, advance the schedule by one row
    always_comb begin
        n_mid.op    = i_item.op;
        n_mid.opnd  = i_item.opnd;
        n_mid.cur   = i_item.sched[0];
        n_mid.sched = pvtcc_pkg::t_sched'(i_item.sched >> ROW_W);
        n_mid.neg   = mul_neg;
        n_mid.mag   = mul_mag;
    end

    // divide stage output
    always_comb begin
        n_item.op    = r_mid.op;
        n_item.opnd  = r_mid.opnd;
        n_item.sched = r_mid.sched;
        n_item.val   = div_val;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_mid_valid <= i_valid;
            r_valid     <= r_mid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mid  <= n_mid;
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // an idle lane passes through the multiply and divide registers unchanged
    `PVTCC_ASSERT_DLY(a_idle_lane_holds, i_clk, i_rst_n, i_valid && (i_item.sched[0][0] == pvtcc_pkg::DIV_NONE), 2, o_valid && (o_item.val[0] == $past(i_item.val[0], 2)))

endmodule

`default_nettype wire

### sv/pvt_sensor_code_conversion.sv
// Top level of the PVT sensor code conversion pipeline.
// Throughput: one beat per cycle; busy stays low, every stage advances each cycle.
// Depth set by the input stage, four multiply/divide steps of two stages each, and the sum.
// Reset: synchronous, active low; clears the valid bits only, no result strobes after it.
`default_nettype none
`include "pvt_sensor_code_conversion_assert.svh"

module pvt_sensor_code_conversion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pvtcc_pkg::OP_W-1:0]          i_op,
    input  logic [pvtcc_pkg::CODE_W-1:0]        i_sensor_code,
    input  logic signed [pvtcc_pkg::PHYS_W-1:0] i_physical_value,
    output logic                                o_done,
    output logic signed [pvtcc_pkg::OUT_W-1:0]  o_converted_value
);

    localparam int NSTEP = pvtcc_pkg::NSTEP;
    localparam int OUT_W = pvtcc_pkg::OUT_W;
    localparam int SUM_W = 22;

    // constant term of each conversion
    localparam int signed OFS_C2T = -48380;
    localparam int signed OFS_T2C = 172;
    localparam int signed OFS_C2V = 620;
    localparam int signed OFS_V2C = -1157;

    logic [NSTEP:0]          chain_valid;
    pvtcc_pkg::t_item        chain_item [NSTEP+1];
    logic signed [SUM_W-1:0] offset;
    logic signed [SUM_W-1:0] n_sum;
    logic                    r_done;
    logic signed [OUT_W-1:0] r_converted_value;

    // pipeline never holds off a beat
    assign busy = 1'b0;

    pvtcc_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (start),
        .i_op             (i_op),
        .i_sensor_code    (i_sensor_code),
        .i_physical_value (i_physical_value),
        .o_valid          (chain_valid[0]),
        .o_item           (chain_item[0])
    );

    // chain of multiply/divide steps
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        pvtcc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[s]),
            .i_item  (chain_item[s]),
            .o_valid (chain_valid[s+1]),
            .o_item  (chain_item[s+1])
        );
    end

    // add the terms and the constant
    always_comb begin
        case (chain_item[NSTEP].op)
            pvtcc_pkg::OP_C2T: offset = SUM_W'(OFS_C2T);
            pvtcc_pkg::OP_T2C: offset = SUM_W'(OFS_T2C);
            pvtcc_pkg::OP_C2V: offset = SUM_W'(OFS_C2V);
            pvtcc_pkg::OP_V2C: offset = SUM_W'(OFS_V2C);
            default:           offset = '0;
        endcase
        n_sum = offset
              + SUM_W'(pvtcc_pkg::t_val'(chain_item[NSTEP].val[0]))
              + SUM_W'(pvtcc_pkg::t_val'(chain_item[NSTEP].val[1]))
              + SUM_W'(pvtcc_pkg::t_val'(chain_item[NSTEP].val[2]))
              + SUM_W'(pvtcc_pkg::t_val'(chain_item[NSTEP].val[3]));
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain_valid[NSTEP];
        end
    end

    // result value
    always_ff @(posedge i_clk) begin
        r_converted_value <= n_sum[OUT_W-1:0];
    end

    assign o_done            = r_done;
    assign o_converted_value = r_converted_value;

    // every accepted beat gives one strobe, and every strobe comes from an accepted beat
    `PVTCC_ASSERT_DLY(a_result_latency, i_clk, i_rst_n, start && !busy, pvtcc_pkg::RES_LAT, o_done)
    `PVTCC_ASSERT_IMP(a_result_source, i_clk, i_rst_n, o_done, $past(start, pvtcc_pkg::RES_LAT))
    // linear conversions stay inside their output span
    `PVTCC_ASSERT_IMP(a_mv_range, i_clk, i_rst_n, o_done && ($past(i_op, pvtcc_pkg::RES_LAT) == pvtcc_pkg::OP_C2V), (o_converted_value >= 19'sd620) && (o_converted_value <= 19'sd1168))
    `PVTCC_ASSERT_IMP(a_vcode_range, i_clk, i_rst_n, o_done && ($past(i_op, pvtcc_pkg::RES_LAT) == pvtcc_pkg::OP_V2C), (o_converted_value >= 19'sd335) && (o_converted_value <= 19'sd708))

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the PVT sensor code conversion pipeline: directed corners, then random beats
module tb_top;

    localparam int OP_W           = pvtcc_pkg::OP_W;
    localparam int CODE_W         = pvtcc_pkg::CODE_W;
    localparam int PHYS_W         = pvtcc_pkg::PHYS_W;
    localparam int OUT_W          = pvtcc_pkg::OUT_W;
    localparam int IDLE_PCT       = 15;
    localparam int N_RANDOM       = 500;
    localparam int WATCHDOG_LIMIT = 2000;

    // Holds expected conversion results in order and checks the DUT output against them
    class conversion_scoreboard;
        logic [OUT_W-1:0] expected_q[$];
        int n_checked;
        int n_errors;

        function new();
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            n_errors++;
        endtask

        // fourth-order polynomial, each term scaled down by 1000 after every multiply
        function longint mdeg_from_code(input longint c);
            longint p4;
            longint p3;
            longint p2;
            longint p1;
            p4 = -16743;
            p3 = 81542;
            p2 = -182010;
            p1 = 310200;
            p4 = p4 * c / 1000; p4 = p4 * c / 1000; p4 = p4 * c / 1000; p4 = p4 * c / 1000;
            p3 = p3 * c / 1000; p3 = p3 * c / 1000; p3 = p3 * c / 1000;
            p2 = p2 * c / 1000; p2 = p2 * c / 1000;
            p1 = p1 * c / 1000;
            return -48380 + p1 + p2 + p3 + p4;
        endfunction

        // cubic on the temperature saturated to -40 C .. 125 C
        function longint code_from_mdeg(input longint t);
            longint q3;
            longint q2;
            longint q1;
            if (t > 125000) t = 125000;
            if (t < -40000) t = -40000;
            q3 = 2617;
            q2 = 8654;
            q1 = 3923;
            q3 = q3 * t / 1000000; q3 = q3 * t / 1000000; q3 = q3 * t / 100000;
            q2 = q2 * t / 1000000; q2 = q2 * t / 1000000;
            q1 = q1 * t / 1000000;
            return 172 + q1 + q2 + q3;
        endfunction

        // one beat accepted: compute its conversion and queue it
        function void note_input(input pvtcc_pkg::t_op op, input logic [CODE_W-1:0] code,
                                 input logic signed [PHYS_W-1:0] phys);
            longint c;
            longint v;
            longint r;
            c = code;
            v = phys;
            case (op)
                pvtcc_pkg::OP_C2T: r = mdeg_from_code(c);
                pvtcc_pkg::OP_T2C: r = code_from_mdeg(v);
                pvtcc_pkg::OP_C2V: r = 620 + (c * 10000) / 18658;
                default: begin
                    if (v > 1000) v = 1000;
                    if (v < 800) v = 800;
                    r = 18658 * v / 10000 - 1157;
                end
            endcase
            expected_q.push_back(r[OUT_W-1:0]);
        endfunction

        task check_result(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] exp_val;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", $signed(got)));
            end else begin
                exp_val = expected_q.pop_front();
                n_checked++;
                if (got !== exp_val)
                    report_mismatch($sformatf("converted_value got %0d expected %0d",
                                              $signed(got), $signed(exp_val)));
            end
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          i_op = '0;
    logic [CODE_W-1:0]        i_sensor_code = '0;
    logic signed [PHYS_W-1:0] i_physical_value = '0;
    logic                     o_done;
    logic signed [OUT_W-1:0]  o_converted_value;

    conversion_scoreboard sb;
    bit idle_on = 1'b1;
    int op_seen[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    pvt_sensor_code_conversion u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_sensor_code     (i_sensor_code),
        .i_physical_value  (i_physical_value),
        .o_done            (o_done),
        .o_converted_value (o_converted_value)
    );

    always #5 i_clk = ~i_clk;

    // monitor: record accepted beats and check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_input(pvtcc_pkg::t_op'(i_op), i_sensor_code, i_physical_value);
                op_seen[i_op]++;
            end
            if (o_done)
                sb.check_result(o_converted_value);
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // drive one beat, with random idle cycles ahead of it when enabled
    task automatic send_beat(input pvtcc_pkg::t_op op, input logic [CODE_W-1:0] code,
                             input logic signed [PHYS_W-1:0] phys);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_op             <= op;
        i_sensor_code    <= code;
        i_physical_value <= phys;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // hold off the sender until every queued result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        pvtcc_pkg::t_op           rop;
        logic [CODE_W-1:0]        rcode;
        logic signed [PHYS_W-1:0] rphys;
        int                       pick;

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // code corners for both code-driven conversions
        send_beat(pvtcc_pkg::OP_C2T, 10'd0,    32'sh80000000);
        send_beat(pvtcc_pkg::OP_C2T, 10'd1,    32'sh7fffffff);
        send_beat(pvtcc_pkg::OP_C2T, 10'd512,  32'sd0);
        send_beat(pvtcc_pkg::OP_C2T, 10'h3ff,  32'shffffffff);
        send_beat(pvtcc_pkg::OP_C2V, 10'd0,    32'sh7fffffff);
        send_beat(pvtcc_pkg::OP_C2V, 10'd511,  32'sh80000000);
        send_beat(pvtcc_pkg::OP_C2V, 10'h3ff,  32'sd0);
        // temperature: saturation on both sides and the full 32-bit extremes
        send_beat(pvtcc_pkg::OP_T2C, 10'h3ff,  32'sh80000000);
        send_beat(pvtcc_pkg::OP_T2C, 10'd0,    -32'sd40001);
        send_beat(pvtcc_pkg::OP_T2C, 10'h3ff,  -32'sd40000);
        send_beat(pvtcc_pkg::OP_T2C, 10'd0,    32'sd0);
        send_beat(pvtcc_pkg::OP_T2C, 10'h3ff,  32'sd124999);
        send_beat(pvtcc_pkg::OP_T2C, 10'd0,    32'sd125000);
        send_beat(pvtcc_pkg::OP_T2C, 10'h3ff,  32'sd125001);
        send_beat(pvtcc_pkg::OP_T2C, 10'd0,    32'sh7fffffff);
        // voltage: saturation to 800..1000 mV
        send_beat(pvtcc_pkg::OP_V2C, 10'h3ff,  32'sh80000000);
        send_beat(pvtcc_pkg::OP_V2C, 10'd0,    32'sd799);
        send_beat(pvtcc_pkg::OP_V2C, 10'h3ff,  32'sd800);
        send_beat(pvtcc_pkg::OP_V2C, 10'd0,    32'sd900);
        send_beat(pvtcc_pkg::OP_V2C, 10'h3ff,  32'sd1000);
        send_beat(pvtcc_pkg::OP_V2C, 10'd0,    32'sd1001);
        send_beat(pvtcc_pkg::OP_V2C, 10'h3ff,  32'sh7fffffff);
        drain_results();

        // random beats, mostly near the clamp windows for the inverse conversions, with a burst free of idles
        for (int i = 0; i < N_RANDOM; i++) begin
            idle_on = (i < 150 || i >= 300);
            if (i == 100)
                drain_results();
            rop  = pvtcc_pkg::t_op'($urandom_range(3));
            pick = $urandom_range(9);
            if (pick == 0)
                rcode = 10'h3ff;
            else if (pick == 1)
                rcode = 10'h000;
            else
                rcode = CODE_W'($urandom_range(1023));
            case (rop)
                pvtcc_pkg::OP_T2C:
                    rphys = (pick < 7) ? ($urandom_range(175000) - 45000) : $urandom;
                pvtcc_pkg::OP_V2C:
                    rphys = (pick < 7) ? ($urandom_range(500) + 650) : $urandom;
                default: rphys = $urandom;
            endcase
            send_beat(rop, rcode, rphys);
        end

        drain_results();
        repeat (pvtcc_pkg::RES_LAT + 4) @(posedge i_clk);

        $display("beats per op: code->mdeg %0d, mdeg->code %0d, code->mV %0d, mV->code %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("%0d results checked, %0d mismatches, %0d still queued",
                 sb.n_checked, sb.n_errors, sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
